>>> hdl/dfst_pkg.sv
`timescale 1ns / 1ps
package dfst_pkg;

  localparam int DFST_MAX_VERTICES = 64;
  localparam int DFST_MAX_EDGES    = 256;

  localparam int MODE_W = 2;
  localparam int VTX_W  = 6;
  localparam int TIME_W = 8;
  localparam int CFG_W  = 7;
  localparam int KIND_W = 2;

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [KIND_W-1:0] KIND_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REC  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic cap_in;
    logic clear_edges;
    logic add_link;
    logic add_commit;
    logic resp_drop;
    logic run_init;
    logic root_next;
    logic discover_root;
    logic head_load;
    logic finish;
    logic pop_load;
    logic edge_apply;
    logic emit_first;
    logic emit_next;
  } dfst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              add_ok;
    logic              root_end;
    logic              root_visited;
    logic              edge_new;
    logic              cur_end;
    logic              sp_one;
    logic              out_last;
  } dfst_sts_t;

endpackage

>>> hdl/depth_first_search_timestamps.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   mode, from_vertex, to_vertex
// out       output     out_valid_o / out_stall_i kind .. last
// cfg       input      cfg_valid_i / cfg_ready_o vertex_count
//
// edge add: a stored edge passes link and commit before its result; a drop skips both
// run: the stack walk reads one registered memory word per step; then a record per vertex
// clear: empties the edge store; reset is asynchronous, active low, and needs no sweep
// a stalled output holds its fields; the next item is taken once it is sent
module depth_first_search_timestamps #(
  parameter int MAX_VERTICES = dfst_pkg::DFST_MAX_VERTICES,
  parameter int MAX_EDGES    = dfst_pkg::DFST_MAX_EDGES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dfst_pkg::CFG_W-1:0]  vertex_count_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dfst_pkg::MODE_W-1:0] mode_i,
  input  logic [dfst_pkg::VTX_W-1:0]  from_vertex_i,
  input  logic [dfst_pkg::VTX_W-1:0]  to_vertex_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dfst_pkg::KIND_W-1:0] kind_o,
  output logic [dfst_pkg::VTX_W-1:0]  vertex_o,
  output logic [dfst_pkg::TIME_W-1:0] discovery_time_o,
  output logic [dfst_pkg::TIME_W-1:0] finish_time_o,
  output logic [dfst_pkg::VTX_W-1:0]  parent_vertex_o,
  output logic                        is_root_o,
  output logic                        last_o
);
  import dfst_pkg::*;

  dfst_cmd_t cmd;
  dfst_sts_t sts;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  dfst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dfst_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (vertex_count_i),
    .mode_i           (mode_i),
    .from_vertex_i    (from_vertex_i),
    .to_vertex_i      (to_vertex_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_o           (kind_o),
    .vertex_o         (vertex_o),
    .discovery_time_o (discovery_time_o),
    .finish_time_o    (finish_time_o),
    .parent_vertex_o  (parent_vertex_o),
    .is_root_o        (is_root_o),
    .last_o           (last_o)
  );

endmodule

>>> hdl/dfst_ctrl.sv
`timescale 1ns / 1ps
module dfst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  dfst_pkg::dfst_sts_t sts_i,
  output dfst_pkg::dfst_cmd_t cmd_o
);
  import dfst_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_LINK = 4'd2;
  localparam logic [3:0] S_COMM = 4'd3;
  localparam logic [3:0] S_RESP = 4'd4;
  localparam logic [3:0] S_INIT = 4'd5;
  localparam logic [3:0] S_ROOT = 4'd6;
  localparam logic [3:0] S_STEP = 4'd7;
  localparam logic [3:0] S_EDGE = 4'd8;
  localparam logic [3:0] S_POP1 = 4'd9;
  localparam logic [3:0] S_POP2 = 4'd10;
  localparam logic [3:0] S_ERD  = 4'd11;
  localparam logic [3:0] S_EOUT = 4'd12;
  localparam logic [3:0] S_HEAD = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.mode)
          MODE_ADD: begin
            if (sts_i.add_ok) begin
              state_d = S_LINK;
            end else begin
              cmd_o.resp_drop = 1'b1;
              state_d         = S_RESP;
            end
          end
          MODE_RUN: state_d = S_INIT;
          MODE_CLEAR: begin
            cmd_o.clear_edges = 1'b1;
            state_d           = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_LINK: begin
        cmd_o.add_link = 1'b1;
        state_d        = S_COMM;
      end
      S_COMM: begin
        cmd_o.add_commit = 1'b1;
        state_d          = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      S_INIT: begin
        cmd_o.run_init = 1'b1;
        state_d        = S_ROOT;
      end
      S_ROOT: begin
        if (sts_i.root_end) begin
          cmd_o.emit_first = 1'b1;
          state_d          = S_ERD;
        end else if (sts_i.root_visited) begin
          cmd_o.root_next = 1'b1;
        end else begin
          cmd_o.discover_root = 1'b1;
          state_d             = S_HEAD;
        end
      end
      // list head of the new top arrives from its registered read
      S_HEAD: begin
        cmd_o.head_load = 1'b1;
        state_d         = S_STEP;
      end
      S_STEP: begin
        if (sts_i.cur_end) begin
          cmd_o.finish = 1'b1;
          state_d      = sts_i.sp_one ? S_ROOT : S_POP1;
        end else begin
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd_o.edge_apply = 1'b1;
        state_d          = sts_i.edge_new ? S_HEAD : S_STEP;
      end
      S_POP1: state_d = S_POP2;
      S_POP2: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_STEP;
      end
      S_ERD: state_d = S_EOUT;
      S_EOUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/dfst_dp.sv
`timescale 1ns / 1ps
module dfst_dp #(
  parameter int MAX_VERTICES = dfst_pkg::DFST_MAX_VERTICES,
  parameter int MAX_EDGES    = dfst_pkg::DFST_MAX_EDGES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dfst_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic [dfst_pkg::MODE_W-1:0] mode_i,
  input  logic [dfst_pkg::VTX_W-1:0]  from_vertex_i,
  input  logic [dfst_pkg::VTX_W-1:0]  to_vertex_i,
  input  dfst_pkg::dfst_cmd_t         cmd_i,
  output dfst_pkg::dfst_sts_t         sts_o,
  output logic [dfst_pkg::KIND_W-1:0] kind_o,
  output logic [dfst_pkg::VTX_W-1:0]  vertex_o,
  output logic [dfst_pkg::TIME_W-1:0] discovery_time_o,
  output logic [dfst_pkg::TIME_W-1:0] finish_time_o,
  output logic [dfst_pkg::VTX_W-1:0]  parent_vertex_o,
  output logic                        is_root_o,
  output logic                        last_o
);
  import dfst_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam logic [CFG_W-1:0] NMAX = CFG_W'(MAX_VERTICES);

  // cursor: end flag above the edge index
  typedef struct packed {
    logic          fin;
    logic [EW-1:0] idx;
  } cur_t;

  typedef struct packed {
    logic [VW-1:0] v;
    cur_t          cur;
  } frame_t;

  logic [CFG_W-1:0]  vcount_q;
  logic [CFG_W-1:0]  n;
  logic [MODE_W-1:0] mode_q;
  logic [VTX_W-1:0]  a_q, b_q;
  logic [ECW-1:0]    ecount_q;
  logic [EW-1:0]     head_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_vld_q;
  logic [MAX_VERTICES-1:0] seen_q;
  logic [CFG_W-1:0]  root_q, oidx_q;
  logic [CFG_W-1:0]  sp_q;
  logic [TIME_W-1:0] clk_cnt_q;
  logic [VW-1:0]     top_v_q;
  cur_t              top_cur_q;
  logic [KIND_W-1:0] kind_q;

  // memories
  logic [VTX_W-1:0]  etgt_mem  [MAX_EDGES];
  cur_t              enext_mem [MAX_EDGES];
  logic [EW-1:0]     tail_mem  [MAX_VERTICES];
  frame_t            stk_mem   [MAX_VERTICES];
  logic [TIME_W-1:0] start_mem [MAX_VERTICES];
  logic [TIME_W-1:0] end_mem   [MAX_VERTICES];
  logic [VW:0]       par_mem   [MAX_VERTICES];

  logic [VTX_W-1:0]  etgt_rd_q;
  cur_t              enext_rd_q;
  logic [EW-1:0]     tail_rd_q;
  logic [EW-1:0]     head_rd_q;
  frame_t            stk_rd_q;
  logic [TIME_W-1:0] start_rd_q, end_rd_q;
  logic [VW:0]       par_rd_q;

  logic [VW-1:0]     a_idx, t_idx, root_idx, sp_idx;
  logic [EW-1:0]     e_idx;
  logic              disc, t_ok;
  logic [VW-1:0]     disc_v;
  logic [TIME_W-1:0] clk_inc;

  always_comb begin
    n = vcount_q;
    if (vcount_q == '0) n = CFG_W'(1);
    if (vcount_q > NMAX) n = NMAX;
  end

  assign a_idx    = a_q[VW-1:0];
  assign t_idx    = etgt_rd_q[VW-1:0];
  assign root_idx = root_q[VW-1:0];
  assign sp_idx   = VW'(sp_q - CFG_W'(1));
  assign e_idx    = ecount_q[EW-1:0];
  assign clk_inc  = clk_cnt_q + TIME_W'(1);
  assign t_ok     = ({1'b0, etgt_rd_q} < n) && !seen_q[t_idx];
  assign disc     = cmd_i.discover_root || (cmd_i.edge_apply && t_ok);
  assign disc_v   = cmd_i.discover_root ? root_idx : t_idx;

  assign sts_o.mode         = mode_q;
  assign sts_o.add_ok       = ({1'b0, a_q} < n) && ({1'b0, b_q} < n)
                              && (ecount_q != ECW'(MAX_EDGES));
  assign sts_o.root_end     = (root_q == n);
  assign sts_o.root_visited = seen_q[root_idx];
  assign sts_o.edge_new     = t_ok;
  assign sts_o.cur_end      = top_cur_q.fin;
  assign sts_o.sp_one       = (sp_q == CFG_W'(1));
  assign sts_o.out_last     = ((oidx_q + CFG_W'(1)) == n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= NMAX;
      mode_q     <= MODE_ADD;
      a_q        <= '0;
      b_q        <= '0;
      ecount_q   <= '0;
      head_vld_q <= '0;
      seen_q     <= '0;
      root_q     <= '0;
      oidx_q     <= '0;
      sp_q       <= '0;
      clk_cnt_q  <= '0;
      top_v_q    <= '0;
      top_cur_q  <= '0;
      kind_q     <= KIND_OK;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_data_i;
      if (cmd_i.cap_in) begin
        mode_q <= mode_i;
        a_q    <= from_vertex_i;
        b_q    <= to_vertex_i;
      end
      if (cmd_i.clear_edges) begin
        head_vld_q <= '0;
        ecount_q   <= '0;
      end
      if (cmd_i.add_commit) begin
        head_vld_q[a_idx] <= 1'b1;
        ecount_q          <= ecount_q + ECW'(1);
        kind_q            <= KIND_OK;
      end
      if (cmd_i.resp_drop) kind_q <= KIND_DROP;
      if (cmd_i.run_init) begin
        seen_q    <= '0;
        clk_cnt_q <= '0;
        root_q    <= '0;
      end
      if (cmd_i.root_next) root_q <= root_q + CFG_W'(1);
      if (cmd_i.edge_apply) top_cur_q <= enext_rd_q;
      if (disc) begin
        clk_cnt_q      <= clk_inc;
        seen_q[disc_v] <= 1'b1;
        top_v_q        <= disc_v;
        sp_q           <= cmd_i.discover_root ? CFG_W'(1) : sp_q + CFG_W'(1);
      end
      if (cmd_i.head_load) top_cur_q <= '{fin: !head_vld_q[top_v_q], idx: head_rd_q};
      if (cmd_i.finish) begin
        clk_cnt_q <= clk_inc;
        sp_q      <= sp_q - CFG_W'(1);
      end
      if (cmd_i.pop_load) begin
        top_v_q   <= stk_rd_q.v;
        top_cur_q <= stk_rd_q.cur;
      end
      if (cmd_i.emit_first) begin
        oidx_q <= '0;
        kind_q <= KIND_REC;
      end
      if (cmd_i.emit_next) oidx_q <= oidx_q + CFG_W'(1);
    end
  end

  // list heads, only meaningful where the valid bit is set
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_commit && !head_vld_q[a_idx]) head_q[a_idx] <= e_idx;
    head_rd_q <= head_q[disc_v];
  end

  // edge store and tails
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_link) begin
      etgt_mem[e_idx] <= b_q;
      if (head_vld_q[a_idx]) enext_mem[tail_rd_q] <= '{fin: 1'b0, idx: e_idx};
    end
    if (cmd_i.add_commit) begin
      enext_mem[e_idx] <= '{fin: 1'b1, idx: '0};
      tail_mem[a_idx]  <= e_idx;
    end
    etgt_rd_q  <= etgt_mem[top_cur_q.idx];
    enext_rd_q <= enext_mem[top_cur_q.idx];
    tail_rd_q  <= tail_mem[a_idx];
  end

  // walk stack holds the frames below the top
  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_apply && t_ok) stk_mem[sp_idx] <= '{v: top_v_q, cur: enext_rd_q};
    stk_rd_q <= stk_mem[sp_idx];
  end

  // per-vertex times and parents
  always_ff @(posedge clk_i) begin
    if (disc) begin
      start_mem[disc_v] <= clk_inc;
      par_mem[disc_v]   <= {cmd_i.discover_root, cmd_i.discover_root ? VW'(0) : top_v_q};
    end
    if (cmd_i.finish) end_mem[top_v_q] <= clk_inc;
    start_rd_q <= start_mem[oidx_q[VW-1:0]];
    end_rd_q   <= end_mem[oidx_q[VW-1:0]];
    par_rd_q   <= par_mem[oidx_q[VW-1:0]];
  end

  always_comb begin
    kind_o           = kind_q;
    vertex_o         = '0;
    discovery_time_o = '0;
    finish_time_o    = '0;
    parent_vertex_o  = '0;
    is_root_o        = 1'b0;
    last_o           = 1'b1;
    if (kind_q == KIND_REC) begin
      vertex_o         = oidx_q[VTX_W-1:0];
      discovery_time_o = start_rd_q;
      finish_time_o    = end_rd_q;
      parent_vertex_o  = VTX_W'(par_rd_q[VW-1:0]);
      is_root_o        = par_rd_q[VW];
      last_o           = sts_o.out_last;
    end
  end

endmodule

>>> hdl/dfst_chk.sv
`timescale 1ns / 1ps
module dfst_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [dfst_pkg::KIND_W-1:0] kind_o,
  input logic [dfst_pkg::VTX_W-1:0]  vertex_o,
  input logic [dfst_pkg::TIME_W-1:0] discovery_time_o,
  input logic [dfst_pkg::TIME_W-1:0] finish_time_o,
  input logic [dfst_pkg::VTX_W-1:0]  parent_vertex_o,
  input logic                        is_root_o,
  input logic                        last_o
);
  import dfst_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output dropped while stalled");

  a_edge_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_REC |-> last_o && vertex_o == '0 && !is_root_o)
    else $error("edge status malformed");

  a_root_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REC && is_root_o |-> parent_vertex_o == '0)
    else $error("root with parent");

  a_times: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REC |-> discovery_time_o < finish_time_o)
    else $error("finish before discovery");

endmodule

bind depth_first_search_timestamps dfst_chk u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .vertex_o         (vertex_o),
  .discovery_time_o (discovery_time_o),
  .finish_time_o    (finish_time_o),
  .parent_vertex_o  (parent_vertex_o),
  .is_root_o        (is_root_o),
  .last_o           (last_o)
);
